@@ src/tvs_pkg.sv @@
// ----------------------------------------------------------------------------
// tvs_pkg
// shared widths, register indexes and constants of the trilinear sampler
// ----------------------------------------------------------------------------
package tvs_pkg;

	localparam int MAX_EXTENT  = 64;
	localparam int STORE_DEPTH = 262144;

	localparam int EXT_W  = 7;                          // extent register width
	localparam int POS_W  = 18;                         // signed Q2.16 position
	localparam int FW     = 16;                         // fraction bits
	localparam int IW     = $clog2(MAX_EXTENT);         // cell index bits
	localparam int CW     = IW + FW;                    // clamped coordinate
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int VAL_W  = 8;
	localparam int LV_W   = VAL_W + FW;                 // Q8.16 interpolated value
	localparam int OUT_W  = 17;
	localparam int NCORN  = 8;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Z = 2'd2;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [EXT_W-1:0] EXT_RESET = 7'd64;

	// ceil(2^32 / 255), exact floor(n/255) for n below 2^24
	localparam logic [24:0] RECIP_255 = 25'd16843010;
	localparam int RECIP_SH = 32;

	function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] e);
		logic [EXT_W-1:0] r;
		r = e;
		if (e < EXT_W'(2))
			r = EXT_W'(2);
		else if (e > EXT_W'(MAX_EXTENT))
			r = EXT_W'(MAX_EXTENT);
		return r;
	endfunction

	// scale a normalized position by an extent and clamp it to zero and to just below the last cell
	function automatic logic [CW-1:0] scale_clamp(input logic signed [POS_W-1:0] p,
			input logic [EXT_W-1:0] e);
		logic signed [POS_W+EXT_W:0] c;
		logic signed [POS_W+EXT_W:0] hi;
		logic [CW-1:0] r;
		c  = p * $signed({1'b0, e});
		hi = $signed({{(POS_W-FW+1){1'b0}}, (e - EXT_W'(1)), {FW{1'b0}}})
			- (POS_W+EXT_W+1)'(7);
		if (c < 0)
			r = '0;
		else if (c > hi)
			r = CW'(hi);
		else
			r = CW'(c);
		return r;
	endfunction

endpackage

@@ src/trilinear_volume_sampler.sv @@
// ----------------------------------------------------------------------------
// trilinear_volume_sampler
// byte-voxel volume store with a fully pipelined trilinear sampler
// ----------------------------------------------------------------------------
// a sample item passes every pipeline stage below before its result shows at the output
// throughput: one item per cycle while the output is not held, writes and samples mixed freely
// the pipeline stalls as a whole only while a result waits at the output
// reset clears valid bits and sets all extents to 64; voxel contents stay
// undefined until written, there is no clearing pass
// ----------------------------------------------------------------------------
module trilinear_volume_sampler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tvs_pkg::EXT_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [tvs_pkg::ADDR_W-1:0]    voxel_address,
	input  logic [tvs_pkg::VAL_W-1:0]     voxel_value,
	input  logic signed [tvs_pkg::POS_W-1:0] pos_x,
	input  logic signed [tvs_pkg::POS_W-1:0] pos_y,
	input  logic signed [tvs_pkg::POS_W-1:0] pos_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tvs_pkg::OUT_W-1:0]     sample_value
);
	import tvs_pkg::*;

	// configuration registers
	logic [EXT_W-1:0] ext_x_q, ext_y_q, ext_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_x_q <= EXT_RESET;
			ext_y_q <= EXT_RESET;
			ext_z_q <= EXT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXTENT_X: ext_x_q <= cfg_data;
				CFG_EXTENT_Y: ext_y_q <= cfg_data;
				CFG_EXTENT_Z: ext_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the whole pipeline moves together unless a result is held at the output
	logic en;
	assign en       = !(out_valid && !out_ready);
	assign in_ready = en;

	logic [EXT_W-1:0] ex_eff, ey_eff, ez_eff;
	assign ex_eff = eff_extent(ext_x_q);
	assign ey_eff = eff_extent(ext_y_q);
	assign ez_eff = eff_extent(ext_z_q);

	// valid and item-type bits travel with the data
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic smp_s1, smp_s2, smp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
			{smp_s1, smp_s2, smp_s3} <= '0;
		end else if (en) begin
			vld_s1 <= in_valid;
			smp_s1 <= (req_type == REQ_SAMPLE);
			vld_s2 <= vld_s1;
			smp_s2 <= smp_s1;
			vld_s3 <= vld_s2;
			smp_s3 <= smp_s2;
			// write items end at the store; only samples go on
			vld_s4 <= vld_s3 && smp_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// stage 1: scale and clamp each axis
	logic [CW-1:0]     cx_s1, cy_s1, cz_s1;
	logic [EXT_W-1:0]  ex_s1, ey_s1;
	logic [ADDR_W-1:0] wa_s1, wa_s2, wa_s3;
	logic [VAL_W-1:0]  wv_s1, wv_s2, wv_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= scale_clamp(pos_x, ex_eff);
			cy_s1 <= scale_clamp(pos_y, ey_eff);
			cz_s1 <= scale_clamp(pos_z, ez_eff);
			ex_s1 <= ex_eff;
			ey_s1 <= ey_eff;
			wa_s1 <= voxel_address;
			wv_s1 <= voxel_value;
		end
	end

	// stage 2: partial linear index y + ey*z and slice stride ex*ey
	logic [IW+EXT_W-1:0]  t_s2;
	logic [2*EXT_W-1:0]   sxy_s2;
	logic [IW-1:0]        ix_s2;
	logic [EXT_W-1:0]     ex_s2;
	logic [FW-1:0]        fx_s2, fy_s2, fz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2   <= (IW+EXT_W)'(cy_s1[CW-1:FW]) + (IW+EXT_W)'(ey_s1 * cz_s1[CW-1:FW]);
			sxy_s2 <= ex_s1 * ey_s1;
			ix_s2  <= cx_s1[CW-1:FW];
			ex_s2  <= ex_s1;
			fx_s2  <= cx_s1[FW-1:0];
			fy_s2  <= cy_s1[FW-1:0];
			fz_s2  <= cz_s1[FW-1:0];
			wa_s2  <= wa_s1;
			wv_s2  <= wv_s1;
		end
	end

	// stage 3: base index x + ex*(y + ey*z), wrapped to the store
	logic [ADDR_W-1:0] base_s3, sxy_s3;
	logic [EXT_W-1:0]  sx_s3;
	logic [FW-1:0]     fx_s3, fy_s3, fz_s3;
	logic [IW+2*EXT_W:0] base_full;

	assign base_full = (IW+2*EXT_W+1)'(ix_s2) + (IW+2*EXT_W+1)'(ex_s2 * t_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			base_s3 <= ADDR_W'(base_full);
			sxy_s3  <= ADDR_W'(sxy_s2);
			sx_s3   <= ex_s2;
			fx_s3   <= fx_s2;
			fy_s3   <= fy_s2;
			fz_s3   <= fz_s2;
			wa_s3   <= wa_s2;
			wv_s3   <= wv_s2;
		end
	end

	// stage 4: eight copies of the store, one per corner; every write goes
	// to all copies, so each copy needs a single read port
	logic [VAL_W-1:0] rd_s4 [NCORN];
	logic [FW-1:0]    fx_s4, fy_s4, fz_s4;

	for (genvar c = 0; c < NCORN; c++) begin : g_corner
		logic [VAL_W-1:0]  mem [STORE_DEPTH];
		logic [ADDR_W-1:0] ca;

		// corner bit 0 steps x, bit 1 steps y, bit 2 steps z
		assign ca = base_s3
			+ ((c & 1) != 0 ? ADDR_W'(1) : '0)
			+ ((c & 2) != 0 ? ADDR_W'(sx_s3) : '0)
			+ ((c & 4) != 0 ? sxy_s3 : '0);

		always_ff @(posedge clk) begin
			if (en && vld_s3 && !smp_s3)
				mem[wa_s3] <= wv_s3;
			if (en)
				rd_s4[c] <= mem[ca];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			fz_s4 <= fz_s3;
		end
	end

	// stage 5: x pass, a*65536 + (b-a)*fx, exact
	logic [LV_W-1:0] vx_s5 [4];
	logic [FW-1:0]   fy_s5, fz_s5;

	for (genvar k = 0; k < 4; k++) begin : g_xpass
		logic signed [VAL_W:0]      d;
		logic signed [VAL_W+FW+1:0] acc;
		assign d   = $signed({1'b0, rd_s4[2*k+1]}) - $signed({1'b0, rd_s4[2*k]});
		assign acc = $signed({2'b00, rd_s4[2*k], {FW{1'b0}}}) + d * $signed({1'b0, fx_s4});
		always_ff @(posedge clk) begin
			if (en)
				vx_s5[k] <= LV_W'(acc);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fy_s5 <= fy_s4;
			fz_s5 <= fz_s4;
		end
	end

	// stage 6: y pass with round half up
	logic [LV_W-1:0] vy_s6 [2];
	logic [FW-1:0]   fz_s6;

	for (genvar k = 0; k < 2; k++) begin : g_ypass
		logic signed [LV_W:0]        d;
		logic signed [LV_W+FW+3:0]   acc;
		assign d   = $signed({1'b0, vx_s5[2*k+1]}) - $signed({1'b0, vx_s5[2*k]});
		assign acc = $signed({4'b0, vx_s5[2*k], {FW{1'b0}}})
			+ (LV_W+FW+4)'(d * $signed({1'b0, fy_s5}))
			+ (LV_W+FW+4)'(32768);
		always_ff @(posedge clk) begin
			if (en)
				vy_s6[k] <= acc[LV_W+FW-1:FW];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			fz_s6 <= fz_s5;
	end

	// stage 7: z pass with round half up
	logic [LV_W-1:0]            vz_s7;
	logic signed [LV_W:0]       dz;
	logic signed [LV_W+FW+3:0]  accz;

	assign dz   = $signed({1'b0, vy_s6[1]}) - $signed({1'b0, vy_s6[0]});
	assign accz = $signed({4'b0, vy_s6[0], {FW{1'b0}}})
		+ (LV_W+FW+4)'(dz * $signed({1'b0, fz_s6}))
		+ (LV_W+FW+4)'(32768);

	always_ff @(posedge clk) begin
		if (en)
			vz_s7 <= accz[LV_W+FW-1:FW];
	end

	// stage 8: round-to-nearest divide by 255 through a reciprocal multiply
	logic [LV_W:0]   num;
	logic [49:0]     qprod;
	logic [OUT_W-1:0] q_s8;

	assign num   = (LV_W+1)'(vz_s7) + (LV_W+1)'(127);
	assign qprod = 50'(num) * 50'(RECIP_255);

	always_ff @(posedge clk) begin
		if (en)
			q_s8 <= qprod[RECIP_SH+OUT_W-1:RECIP_SH];
	end

	assign out_valid    = vld_s8;
	assign sample_value = q_s8;

	// checks
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample_value <= OUT_W'(65536)))
		else $error("sample value above one");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("stall without a waiting result");

	a_cell_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && smp_s1 |-> (EXT_W'(cx_s1[CW-1:FW]) + EXT_W'(1) < ex_s1))
		else $error("x cell beyond last interval");

endmodule
